### rtl/sid_pkg.sv
// Shared types and constants for the signed integer divider.
// Holds the default data width and the control bundle sent to the divider cells.
// No dependencies.
package sid_pkg;

  // Default operand width.
  localparam int unsigned DATA_WIDTH_DEF = 32;

  // Control bundle broadcast from the sequencer to every cell of the row.
  typedef struct packed {
    logic load;  // capture operand magnitudes and clear the remainder
    logic step;  // perform one shift-and-subtract iteration
    logic take;  // trial subtraction did not borrow, keep the difference
  } cell_ctrl_t;

endpackage

### rtl/sid_in_if.sv
// Operand channel of the signed integer divider: valid/ready plus both operands.
// Stands alone; the width is set by the instantiating level.
interface sid_in_if #(
  parameter int unsigned W = 32
);
  logic         valid;
  logic         ready;
  logic [W-1:0] numerator;
  logic [W-1:0] denominator;

  modport source (output valid, output numerator, output denominator, input ready);
  modport sink   (input valid, input numerator, input denominator, output ready);
endinterface

### rtl/sid_out_if.sv
// Result channel of the signed integer divider: valid/ready plus the quotient.
// Stands alone; the width is set by the instantiating level.
interface sid_out_if #(
  parameter int unsigned W = 32
);
  logic         valid;
  logic         ready;
  logic [W-1:0] quotient;

  modport source (output valid, output quotient, input ready);
  modport sink   (input valid, input quotient, output ready);
endinterface

### rtl/sid_cell.sv
// One bit slice of the restoring divider row: remainder, divisor and
// dividend/quotient bits plus one stage of the borrow chain.
// Depends on sid_pkg for the control bundle.
module sid_cell (
  input  logic              clk,
  input  sid_pkg::cell_ctrl_t ctrl,
  input  logic              load_nq,
  input  logic              load_d,
  input  logic              rem_in,
  input  logic              nq_in,
  input  logic              borrow_in,
  output logic              rem_out,
  output logic              nq_out,
  output logic              borrow_out
);

  logic rem;
  logic nq;
  logic d;
  logic trial;
  logic diff;

  // The shifted remainder bit arrives from the lower neighbor.
  assign trial      = rem_in;
  assign diff       = trial ^ d ^ borrow_in;
  assign borrow_out = (~trial & d) | (~(trial ^ d) & borrow_in);

  // Load operands, or shift one position and keep or restore the remainder.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      rem <= 1'b0;
      nq  <= load_nq;
      d   <= load_d;
    end else if (ctrl.step) begin
      rem <= ctrl.take ? diff : trial;
      nq  <= nq_in;
    end
  end

  assign rem_out = rem;
  assign nq_out  = nq;

endmodule

### rtl/signed_int_divider.sv
// Signed integer divider, quotient truncated toward zero, saturating on overflow.
// Built from a row of sid_cell bit slices; uses sid_pkg, sid_in_if and sid_out_if.
//
//   channel    | role   | payload
//   operands   | sink   | numerator, denominator (DATA_WIDTH bits each, signed)
//   result     | source | quotient (DATA_WIDTH bits, signed)
//
// An item passes through the load of the magnitudes, DATA_WIDTH iterations of the
// cell row (one quotient bit per cycle), and the sign fix.
// The next transfer on operands is taken once the previous result has moved into
// the output register, which may still be waiting on result.ready.
// A stalled result holds the sequencer in its final state until the register frees.
// Reset (rst, synchronous) clears the sequencer and the output valid flag.
module signed_int_divider #(
  parameter int unsigned DATA_WIDTH = sid_pkg::DATA_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  sid_in_if.sink    operands,
  sid_out_if.source result
);

  localparam int unsigned CNT_W = $clog2(DATA_WIDTH);
  localparam logic [DATA_WIDTH-1:0] MAX_POS = {1'b0, {(DATA_WIDTH-1){1'b1}}};

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

  state_t              state;
  state_t              state_next;
  logic [CNT_W-1:0]    cnt;
  logic                neg;
  logic                zero_div;
  logic                out_valid;
  logic [DATA_WIDTH-1:0] out_quot;
  logic [DATA_WIDTH-1:0] res_next;

  sid_pkg::cell_ctrl_t ctrl;
  logic                in_xfer;
  logic                res_load;
  logic [DATA_WIDTH-1:0] mag_n;
  logic [DATA_WIDTH-1:0] mag_d;
  logic [DATA_WIDTH-1:0] rem_bits;
  logic [DATA_WIDTH-1:0] nq_bits;
  logic [DATA_WIDTH:0]   borrow;

  // Handshakes.
  assign operands.ready = (state == ST_IDLE);
  assign in_xfer        = operands.valid && operands.ready;
  assign res_load       = (state == ST_FIN) && (!out_valid || result.ready);

  // Operand magnitudes; the most negative value maps to 2^(W-1) unsigned.
  assign mag_n = operands.numerator[DATA_WIDTH-1] ? ('0 - operands.numerator)
                                                  : operands.numerator;
  assign mag_d = operands.denominator[DATA_WIDTH-1] ? ('0 - operands.denominator)
                                                    : operands.denominator;

  // Control broadcast to the cell row.
  assign ctrl.load = in_xfer;
  assign ctrl.step = (state == ST_RUN);
  assign ctrl.take = ~borrow[DATA_WIDTH];

  // Row of bit-slice cells with a ripple borrow chain.
  assign borrow[0] = 1'b0;
  for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_cell
    logic rem_in;
    logic nq_in;
    if (i == 0) begin : g_low
      assign rem_in = nq_bits[DATA_WIDTH-1];
      assign nq_in  = ctrl.take;
    end else begin : g_mid
      assign rem_in = rem_bits[i-1];
      assign nq_in  = nq_bits[i-1];
    end
    sid_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .load_nq   (mag_n[i]),
      .load_d    (mag_d[i]),
      .rem_in    (rem_in),
      .nq_in     (nq_in),
      .borrow_in (borrow[i]),
      .rem_out   (rem_bits[i]),
      .nq_out    (nq_bits[i]),
      .borrow_out(borrow[i+1])
    );
  end

  // Sequencer next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_xfer) state_next = ST_RUN;
      ST_RUN:  if (cnt == '0) state_next = ST_FIN;
      ST_FIN:  if (res_load) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (in_xfer) begin
        cnt <= CNT_W'(DATA_WIDTH - 1);
      end else if (state == ST_RUN) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  // Sign and special-case flags captured with the operands.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      neg      <= operands.numerator[DATA_WIDTH-1] ^ operands.denominator[DATA_WIDTH-1];
      zero_div <= (operands.denominator == '0);
    end
  end

  // Sign fix and saturation of the unsigned quotient.
  always_comb begin
    if (zero_div) begin
      res_next = '0;
    end else if (neg) begin
      res_next = '0 - nq_bits;
    end else if (nq_bits[DATA_WIDTH-1]) begin
      res_next = MAX_POS;
    end else begin
      res_next = nq_bits;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_quot <= res_next;
    end
  end

  assign result.valid    = out_valid;
  assign result.quotient = out_quot;

`ifndef SYNTHESIS
  // An accepted transfer starts a full-length run.
  a_start: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> (state == ST_RUN) && (cnt == CNT_W'(DATA_WIDTH - 1)))
    else $error("divider did not start a full run after operand transfer");

  // The last iteration leads to the sign-fix state.
  a_finish: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_RUN) && (cnt == '0)) |=> (state == ST_FIN))
    else $error("divider did not finish after the last iteration");

  // Division by zero always yields a zero quotient.
  a_zero: assert property (@(posedge clk) disable iff (rst)
    (res_load && zero_div) |=> (out_quot == '0))
    else $error("divide by zero did not produce zero");

  // A result only appears after the sign-fix state.
  a_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_FIN))
    else $error("result valid rose outside the sign-fix state");
`endif

endmodule
